// ===== rtl/csb_pkg.sv =====
// Shared types and constants of the clipped color-key sprite blitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package csb_pkg;

  localparam int MaxSpriteSide = 256;
  localparam int AddrBits      = 24;

  localparam int SideW  = 9;                       // sprite size field
  localparam int CntW   = $clog2(MaxSpriteSide);   // column and row counters
  localparam int CoordW = 13;                      // screen coordinates
  localparam int PitchW = 14;
  localparam int ProdW  = CoordW + PitchW + 1;     // signed row times pitch
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 14;

  localparam logic [0:0] OpStart = 1'b0;
  localparam logic [0:0] OpPixel = 1'b1;

  localparam logic [CfgIdxW-1:0] RegScreenWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegScreenHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLinePitch    = 2'd2;

  typedef struct packed {
    logic [CoordW-1:0] disp_w;
    logic [CoordW-1:0] disp_h;
    logic [PitchW-1:0] line_pitch;
  } csb_cfg_t;

  // One visible pixel handed from the front to the back.
  typedef struct packed {
    logic [CoordW-1:0]   org_y;     // two's complement sprite top row
    logic [PitchW-1:0]   pitch;     // line pitch at sprite start
    logic [AddrBits-1:0] row_off;   // pitches added since sprite start
    logic [CoordW-1:0]   col_x;     // screen column, known non-negative
    logic [7:0]          pixel;
  } csb_entry_t;

  function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] v);
    logic [SideW-1:0] s;
    s = v;
    if (v == '0) s = SideW'(1);
    else if (v > SideW'(MaxSpriteSide)) s = SideW'(MaxSpriteSide);
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/csb_front.sv =====
// Front part: takes start and pixel items, tracks column, row and row offset,
// and classifies each pixel as visible or not. Uses csb_pkg.
`default_nettype none

module csb_front import csb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire csb_cfg_t          cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [0:0]        opcode_i,
  input  wire logic [CoordW-1:0] pos_x_i,
  input  wire logic [CoordW-1:0] pos_y_i,
  input  wire logic [SideW-1:0]  sprite_width_i,
  input  wire logic [SideW-1:0]  sprite_height_i,
  input  wire logic [7:0]        pixel_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output csb_entry_t             q_data_o
);

  logic                active_q, active_d;
  logic [CoordW-1:0]   org_x_q, org_x_d;
  logic [CoordW-1:0]   org_y_q, org_y_d;
  logic [SideW-1:0]    wid_q, wid_d;
  logic [SideW-1:0]    hgt_q, hgt_d;
  logic [CntW-1:0]     col_q, col_d;
  logic [CntW-1:0]     row_q, row_d;
  logic [PitchW-1:0]   pitch0_q, pitch0_d;
  logic [AddrBits-1:0] row_off_q, row_off_d;

  logic              accept;
  logic [CoordW:0]   sx, sy;
  logic [SideW-1:0]  col_nxt, row_nxt;
  logic              visible;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign sx = {org_x_q[CoordW-1], org_x_q} + {{(CoordW+1-CntW){1'b0}}, col_q};
  assign sy = {org_y_q[CoordW-1], org_y_q} + {{(CoordW+1-CntW){1'b0}}, row_q};
  assign col_nxt = {1'b0, col_q} + SideW'(1);
  assign row_nxt = {1'b0, row_q} + SideW'(1);

  assign visible = active_q && (pixel_i != 8'd0) && !sx[CoordW] && !sy[CoordW] &&
                   (sx[CoordW-1:0] < cfg_i.disp_w) &&
                   (sy[CoordW-1:0] < cfg_i.disp_h);

  assign q_push_o          = accept && (opcode_i == OpPixel) && visible;
  assign q_data_o.org_y    = org_y_q;
  assign q_data_o.pitch    = pitch0_q;
  assign q_data_o.row_off  = row_off_q;
  assign q_data_o.col_x    = sx[CoordW-1:0];
  assign q_data_o.pixel    = pixel_i;

  always_comb begin
    active_d  = active_q;
    org_x_d   = org_x_q;
    org_y_d   = org_y_q;
    wid_d     = wid_q;
    hgt_d     = hgt_q;
    col_d     = col_q;
    row_d     = row_q;
    pitch0_d  = pitch0_q;
    row_off_d = row_off_q;
    if (accept) begin
      if (opcode_i == OpStart) begin
        active_d  = 1'b1;
        org_x_d   = pos_x_i;
        org_y_d   = pos_y_i;
        wid_d     = clamp_side(sprite_width_i);
        hgt_d     = clamp_side(sprite_height_i);
        col_d     = '0;
        row_d     = '0;
        pitch0_d  = cfg_i.line_pitch;
        row_off_d = '0;
      end else if (active_q) begin
        if (col_nxt >= wid_q) begin
          // end of a sprite row: wrap column, step row and row offset
          col_d     = '0;
          row_d     = row_nxt[CntW-1:0];
          row_off_d = row_off_q + {{(AddrBits-PitchW){1'b0}}, cfg_i.line_pitch};
          if (row_nxt >= hgt_q) active_d = 1'b0;
        end else begin
          col_d = col_nxt[CntW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      org_x_q   <= '0;
      org_y_q   <= '0;
      wid_q     <= '0;
      hgt_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      pitch0_q  <= '0;
      row_off_q <= '0;
    end else begin
      active_q  <= active_d;
      org_x_q   <= org_x_d;
      org_y_q   <= org_y_d;
      wid_q     <= wid_d;
      hgt_q     <= hgt_d;
      col_q     <= col_d;
      row_q     <= row_d;
      pitch0_q  <= pitch0_d;
      row_off_q <= row_off_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csb_queue.sv =====
// Two-entry queue of visible pixels between the front and the back.
// Uses csb_pkg for the entry type.
`default_nettype none

module csb_queue import csb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire csb_entry_t push_data_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            nonempty_o,
  output csb_entry_t      head_o
);

  csb_entry_t  slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign nonempty_o = (count_q != 2'd0);
  assign head_o     = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csb_back.sv =====
// Back part: forms the framebuffer offset of a visible pixel in two stages
// (row-base multiply, then final add) and holds it in the output register.
`default_nettype none

module csb_back import csb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_nonempty_i,
  input  wire csb_entry_t         q_head_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [AddrBits-1:0]     write_address_o,
  output logic [7:0]              write_pixel_o
);

  logic                s1_valid_q, s1_valid_d;
  logic [AddrBits-1:0] s1_base_q;
  logic [AddrBits-1:0] s1_part_q;
  logic [7:0]          s1_pixel_q;
  logic                s2_valid_q, s2_valid_d;
  logic [AddrBits-1:0] s2_addr_q;
  logic [7:0]          s2_pixel_q;

  logic                s2_adv, s1_adv;
  logic [ProdW-1:0]    prod;

  assign s2_adv  = !s2_valid_q || out_ready_i;
  assign s1_adv  = !s1_valid_q || s2_adv;
  assign q_pop_o = q_nonempty_i && s1_adv;

  assign prod = ProdW'($signed(q_head_i.org_y) * $signed({1'b0, q_head_i.pitch}));

  assign s1_valid_d = s1_adv ? q_nonempty_i : s1_valid_q;
  assign s2_valid_d = s2_adv ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_base_q  <= prod[AddrBits-1:0];
      s1_part_q  <= q_head_i.row_off +
                    {{(AddrBits-CoordW){1'b0}}, q_head_i.col_x};
      s1_pixel_q <= q_head_i.pixel;
    end
    if (s2_adv && s1_valid_q) begin
      s2_addr_q  <= s1_base_q + s1_part_q;
      s2_pixel_q <= s1_pixel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  assign out_valid_o     = s2_valid_q;
  assign write_address_o = s2_addr_q;
  assign write_pixel_o   = s2_pixel_q;

endmodule

`default_nettype wire

// ===== rtl/clipped_transparent_sprite_blit.sv =====
// Sprite blitter with screen clipping and color-key transparency.
// Input channel (in_valid_i / in_ready_o): a start item (opcode 0) latches the
// signed screen position and the size of a sprite; pixel items (opcode 1) then
// follow in raster order, one source pixel per item. Output channel
// (out_valid_o / out_ready_i): one framebuffer write per nonzero pixel that
// falls inside the screen rectangle, giving the offset x + y * line_pitch
// (wrapped to the address width) and the pixel value. Start items and
// transparent or clipped pixels give no write.
// Throughput: one item per clock while the queue is not full; the front
// counters and the incremental row offset update with each accepted item,
// and the back retires one write per cycle while out_ready_i is high. A
// write passes the queue slot, the row-base multiply stage and the output register.
// Receiver stall: the output register holds, the back stages fill, then the
// two-entry queue fills and in_ready_o drops; nothing is lost.
// Reset: clears all control state; no sprite is active, so pixels before the
// first start are dropped. Registers return to 640 x 480, pitch 640.
// Configuration: cfg_we_i writes register cfg_index_i (0 width, 1 height,
// 2 pitch); write only while no write is pending.
// Depends on csb_pkg, csb_front, csb_queue and csb_back.
`default_nettype none

module clipped_transparent_sprite_blit import csb_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [0:0]          opcode_i,
  input  wire logic [CoordW-1:0]   pos_x_i,
  input  wire logic [CoordW-1:0]   pos_y_i,
  input  wire logic [SideW-1:0]    sprite_width_i,
  input  wire logic [SideW-1:0]    sprite_height_i,
  input  wire logic [7:0]          pixel_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [AddrBits-1:0]      write_address_o,
  output logic [7:0]               write_pixel_o
);

  csb_cfg_t   cfg_q, cfg_d;
  logic       q_full, q_push, q_pop, q_nonempty;
  csb_entry_t q_in, q_head;

  // Configuration registers: take a write at once, ignore unknown indexes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegScreenWidth:  cfg_d.disp_w     = cfg_data_i[CoordW-1:0];
        RegScreenHeight: cfg_d.disp_h     = cfg_data_i[CoordW-1:0];
        RegLinePitch:    cfg_d.line_pitch = cfg_data_i[PitchW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.disp_w     <= CoordW'(640);
      cfg_q.disp_h     <= CoordW'(480);
      cfg_q.line_pitch <= PitchW'(640);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept and classify items, advance the sprite raster position.
  csb_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i           (cfg_q),
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .pos_x_i,
    .pos_y_i,
    .sprite_width_i,
    .sprite_height_i,
    .pixel_i,
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_in)
  );

  // Queue: decouple the front from stalls on the output side.
  csb_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .nonempty_o  (q_nonempty),
    .head_o      (q_head)
  );

  // Back: build the framebuffer offset and hold the write for the receiver.
  csb_back u_back (
    .clk_i,
    .rst_ni,
    .q_nonempty_i    (q_nonempty),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .out_valid_o,
    .out_ready_i,
    .write_address_o,
    .write_pixel_o
  );

endmodule

`default_nettype wire
